// ----- src/scc_pkg.sv -----
// Shared types and constants for the strongly connected components block.
// Depends on nothing; every other file takes names from here by scope.
package scc_pkg;

    localparam int NODE_W = 7;
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 1024;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
        logic              has_edge;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] label;
        logic [NODE_W-1:0] component_count;
        logic              edge_overflow;
        logic              last_result;
    } result_t;

    // Classified command from front to back; tail and head are node minus one.
    typedef struct packed {
        logic              is_edge;
        logic              is_last;
        logic              ovf;
        logic [NODE_W-1:0] tail;
        logic [NODE_W-1:0] head;
    } cmd_t;

endpackage

// ----- src/scc_front.sv -----
// Front end: accepts item beats, range-checks edges and tracks store fill.
// Depends on scc_pkg for item_t and cmd_t.
module scc_front #(
    parameter int MAX_EDGES = scc_pkg::DEF_MAX_EDGES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  scc_pkg::item_t             in_item,
    input  logic [scc_pkg::NODE_W-1:0] n_eff,
    input  logic                       q_full,
    output logic                       in_stall,
    output logic                       push,
    output scc_pkg::cmd_t              cmd
);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int OW = scc_pkg::NODE_W;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic          acc, bad, good;

    assign in_stall = q_full;
    assign acc = in_valid && !q_full;

    always_comb
    begin
        bad = (in_item.src_node == '0) || (in_item.src_node > n_eff) ||
              (in_item.dst_node == '0) || (in_item.dst_node > n_eff) ||
              (cnt_reg >= CW'(MAX_EDGES));
        good = in_item.has_edge && !bad;
        cmd.is_edge = good;
        cmd.is_last = in_item.last;
        cmd.ovf = ovf_reg || (in_item.has_edge && bad);
        cmd.tail = in_item.src_node - OW'(1);
        cmd.head = in_item.dst_node - OW'(1);
        push = acc && (good || in_item.last);
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (acc)
        begin
            if (in_item.last)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                ovf_next = cmd.ovf;
                if (good)
                    cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end
endmodule

// ----- src/scc_queue.sv -----
// Short command queue between the front end and the walk engine.
// Depends on scc_pkg for cmd_t and the queue depth.
module scc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  scc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output scc_pkg::cmd_t head_cmd,
    output logic          full,
    output logic          empty
);
    localparam int D = scc_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(D);
    localparam int NW = $clog2(D + 1);

    scc_pkg::cmd_t mem [D];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [NW-1:0] cnt_reg;

    assign full = (cnt_reg == NW'(D));
    assign empty = (cnt_reg == '0);
    assign head_cmd = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wp_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= (wp_reg == PW'(D - 1)) ? '0 : wp_reg + PW'(1);
            if (pop && !empty)
                rp_reg <= (rp_reg == PW'(D - 1)) ? '0 : rp_reg + PW'(1);
            cnt_reg <= cnt_reg + NW'(push && !full) - NW'(pop && !empty);
        end
    end
endmodule

// ----- src/scc_walk.sv -----
// Back end: stores edges, runs both depth-first passes and emits one beat per node.
// Depends on scc_pkg for cmd_t and result_t.
module scc_walk #(
    parameter int MAX_NODES = scc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = scc_pkg::DEF_MAX_EDGES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [scc_pkg::NODE_W-1:0] n_eff,
    input  logic                       q_empty,
    input  scc_pkg::cmd_t              q_cmd,
    output logic                       q_pop,
    input  logic                       result_stall,
    output logic                       result_valid,
    output scc_pkg::result_t           result
);
    localparam int NW = $clog2(MAX_NODES);
    localparam int DW = $clog2(MAX_NODES + 1);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int OW = scc_pkg::NODE_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_OUT1 = 9'b000000010,
        S_SCAN = 9'b000000100,
        S_TEST = 9'b000001000,
        S_POP  = 9'b000010000,
        S_OUT2 = 9'b000100000,
        S_FCHK = 9'b001000000,
        S_EMRD = 9'b010000000,
        S_EMIT = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [NW-1:0] v;
        logic [CW-1:0] c;
    } frame_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    ecnt_reg, ecnt_next, c_reg, c_next;
    logic             ovf_reg, ovf_next, rev_reg, rev_next;
    logic [DW-1:0]    i_reg, i_next, depth_reg, depth_next;
    logic [DW-1:0]    fin_reg, fin_next, j_reg, j_next, comps_reg, comps_next;
    logic [NW-1:0]    v_reg, v_next;
    logic [MAX_NODES-1:0] vis_reg, vis_next;
    logic             ov_reg, ov_next;
    scc_pkg::result_t out_reg, out_next;

    logic [2*NW-1:0]  emem [MAX_EDGES];
    frame_t           smem [MAX_NODES];
    logic [NW-1:0]    fmem [MAX_NODES];
    logic [NW-1:0]    lmem [MAX_NODES];
    logic [2*NW-1:0]  e_rd;
    frame_t           s_rd;
    logic [NW-1:0]    f_rd, l_rd;

    logic             e_we, e_re, s_we, s_re, f_we, f_re, l_we, l_re;
    logic [EW-1:0]    e_wa, e_ra;
    logic [2*NW-1:0]  e_wd;
    logic [NW-1:0]    s_wa, s_ra, f_wa, f_ra, l_wa, l_ra, l_wd;
    frame_t           s_wd;
    logic [NW-1:0]    from_n, to_n;
    logic             hit;
    logic [DW-1:0]    n_d;

    assign result_valid = ov_reg;
    assign result = out_reg;
    assign n_d = DW'(n_eff);

    always_ff @(posedge clk)
    begin
        if (e_we)
            emem[e_wa] <= e_wd;
        if (e_re)
            e_rd <= emem[e_ra];
        if (s_we)
            smem[s_wa] <= s_wd;
        if (s_re)
            s_rd <= smem[s_ra];
        if (f_we)
            fmem[f_wa] <= v_reg;
        if (f_re)
            f_rd <= fmem[f_ra];
        if (l_we)
            lmem[l_wa] <= l_wd;
        if (l_re)
            l_rd <= lmem[l_ra];
    end

    always_comb
    begin
        state_next = state_reg;
        ecnt_next = ecnt_reg;
        c_next = c_reg;
        ovf_next = ovf_reg;
        rev_next = rev_reg;
        i_next = i_reg;
        depth_next = depth_reg;
        fin_next = fin_reg;
        j_next = j_reg;
        comps_next = comps_reg;
        v_next = v_reg;
        vis_next = vis_reg;
        ov_next = ov_reg && result_stall;
        out_next = out_reg;
        q_pop = 1'b0;
        e_we = 1'b0; e_re = 1'b0; s_we = 1'b0; s_re = 1'b0;
        f_we = 1'b0; f_re = 1'b0; l_we = 1'b0; l_re = 1'b0;
        e_wa = ecnt_reg[EW-1:0];
        e_wd = {q_cmd.tail[NW-1:0], q_cmd.head[NW-1:0]};
        e_ra = c_reg[EW-1:0];
        s_wa = NW'(depth_reg - DW'(1));
        s_wd = '{v: v_reg, c: c_reg};
        s_ra = NW'(depth_reg - DW'(2));
        f_wa = fin_reg[NW-1:0];
        f_ra = NW'(j_reg - DW'(1));
        l_wa = rev_reg ? to_n : f_rd;
        l_wd = NW'(comps_reg - DW'(1));
        l_ra = i_reg[NW-1:0];
        from_n = rev_reg ? e_rd[NW-1:0] : e_rd[2*NW-1:NW];
        to_n = rev_reg ? e_rd[2*NW-1:NW] : e_rd[NW-1:0];
        hit = (from_n == v_reg) && (DW'(to_n) < n_d) && (DW'(from_n) < n_d) &&
              (vis_reg[to_n] == rev_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.is_edge)
                    begin
                        e_we = 1'b1;
                        ecnt_next = ecnt_reg + CW'(1);
                    end
                    if (q_cmd.is_last)
                    begin
                        ovf_next = q_cmd.ovf;
                        vis_next = '0;
                        i_next = '0;
                        fin_next = '0;
                        state_next = S_OUT1;
                    end
                end
            end
            S_OUT1:
            begin
                if (i_reg < n_d)
                begin
                    if (!vis_reg[i_reg[NW-1:0]])
                    begin
                        vis_next[i_reg[NW-1:0]] = 1'b1;
                        v_next = i_reg[NW-1:0];
                        c_next = '0;
                        depth_next = DW'(1);
                        rev_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                        i_next = i_reg + DW'(1);
                end
                else
                begin
                    j_next = fin_reg;
                    comps_next = '0;
                    state_next = S_OUT2;
                end
            end
            S_SCAN:
            begin
                if (c_reg < ecnt_reg)
                begin
                    e_re = 1'b1;
                    c_next = c_reg + CW'(1);
                    state_next = S_TEST;
                end
                else
                begin
                    if (!rev_reg && fin_reg < DW'(MAX_NODES))
                    begin
                        f_we = 1'b1;
                        fin_next = fin_reg + DW'(1);
                    end
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg == DW'(1))
                        state_next = rev_reg ? S_OUT2 : S_OUT1;
                    else
                    begin
                        s_re = 1'b1;
                        state_next = S_POP;
                    end
                end
            end
            S_TEST:
            begin
                state_next = S_SCAN;
                if (hit)
                begin
                    vis_next[to_n] = !rev_reg;
                    l_we = rev_reg;
                    if (depth_reg < DW'(MAX_NODES))
                    begin
                        s_we = 1'b1;
                        v_next = to_n;
                        c_next = '0;
                        depth_next = depth_reg + DW'(1);
                    end
                end
            end
            S_POP:
            begin
                v_next = s_rd.v;
                c_next = s_rd.c;
                state_next = S_SCAN;
            end
            S_OUT2:
            begin
                if (j_reg != '0)
                begin
                    f_re = 1'b1;
                    j_next = j_reg - DW'(1);
                    state_next = S_FCHK;
                end
                else
                begin
                    i_next = '0;
                    state_next = S_EMRD;
                end
            end
            S_FCHK:
            begin
                state_next = S_OUT2;
                if (vis_reg[f_rd])
                begin
                    comps_next = comps_reg + DW'(1);
                    vis_next[f_rd] = 1'b0;
                    l_we = 1'b1;
                    l_wa = f_rd;
                    l_wd = comps_reg[NW-1:0];
                    v_next = f_rd;
                    c_next = '0;
                    depth_next = DW'(1);
                    rev_next = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_EMRD:
            begin
                l_re = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ov_reg || !result_stall)
                begin
                    ov_next = 1'b1;
                    out_next.node = OW'(i_reg) + OW'(1);
                    out_next.label = OW'(l_rd) + OW'(1);
                    out_next.component_count = OW'(comps_reg);
                    out_next.edge_overflow = ovf_reg;
                    out_next.last_result = (i_reg + DW'(1) == n_d);
                    if (i_reg + DW'(1) == n_d)
                    begin
                        ecnt_next = '0;
                        ovf_next = 1'b0;
                        vis_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + DW'(1);
                        state_next = S_EMRD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ecnt_reg <= '0;
            ovf_reg <= 1'b0;
            vis_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ecnt_reg <= ecnt_next;
            ovf_reg <= ovf_next;
            vis_reg <= vis_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        rev_reg <= rev_next;
        i_reg <= i_next;
        depth_reg <= depth_next;
        fin_reg <= fin_next;
        j_reg <= j_next;
        comps_reg <= comps_next;
        v_reg <= v_next;
        out_reg <= out_next;
    end
endmodule

// ----- src/strongly_connected_components.sv -----
// Top level of the strongly connected components block.
// Depends on scc_pkg, scc_front, scc_queue and scc_walk.
//
// Usage: the item channel (item_valid, item_stall, item) carries one directed
// edge per beat. Beats are taken one per cycle while the command queue has
// room; edges with an endpoint outside 1..node_count, or beyond MAX_EDGES
// stored, are dropped and flagged. A beat with last set starts the walk.
// Walk: each edge scanned takes an edge memory read and then a test, and every
// stack frame scans the edge list once in each of the two passes; the walk time
// is set by the single edge memory read port. Then one result beat per node
// (result_valid, result_stall, result) issues, node 1 first; last_result
// marks the highest node. A stalled result holds in the output register and
// the walk engine waits; item beats keep queuing until the queue fills.
// The config channel (cfg_valid, cfg_ready, cfg_data) writes node_count and
// is always ready; write it only while the block is idle.
// Reset clears node_count to one, the edge count and the walk state machine.
module strongly_connected_components #(
    parameter int MAX_NODES = scc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = scc_pkg::DEF_MAX_EDGES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  scc_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output scc_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [scc_pkg::NODE_W-1:0] cfg_data
);
    localparam int OW = scc_pkg::NODE_W;

    logic [OW-1:0] nc_reg, n_eff;
    logic          push, q_full, q_empty, q_pop;
    scc_pkg::cmd_t cmd, q_cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (nc_reg == '0)
            n_eff = OW'(1);
        else if (nc_reg > OW'(MAX_NODES))
            n_eff = OW'(MAX_NODES);
        else
            n_eff = nc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nc_reg <= OW'(1);
        else if (cfg_valid && cfg_ready)
            nc_reg <= cfg_data;
    end

    scc_front #(.MAX_EDGES(MAX_EDGES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(item_valid), .in_item(item),
        .n_eff(n_eff), .q_full(q_full), .in_stall(item_stall),
        .push(push), .cmd(cmd)
    );

    scc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(cmd), .pop(q_pop),
        .head_cmd(q_cmd), .full(q_full), .empty(q_empty)
    );

    scc_walk #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_walk (
        .clk(clk), .rst_n(rst_n), .n_eff(n_eff), .q_empty(q_empty),
        .q_cmd(q_cmd), .q_pop(q_pop), .result_stall(result_stall),
        .result_valid(result_valid), .result(result)
    );
endmodule
